// ===== hw/rtl/template_tag_lexer_core_assert.svh =====
// Assertion macros for the template tag lexer.
`ifndef TEMPLATE_TAG_LEXER_CORE_ASSERT_SVH
`define TEMPLATE_TAG_LEXER_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define TLEX_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlex check failed");
// Next-cycle implication.
`define TLEX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlex check failed");
`else
`define TLEX_ASSERT_IMPL(label, ante, cons)
`define TLEX_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/tlex_pkg.sv =====
package tlex_pkg;

  typedef enum logic [2:0] {
    ModeText    = 3'd0,
    ModeOpen    = 3'd1,
    ModeClose   = 3'd2,
    ModeSymbol  = 3'd3,
    ModeInclude = 3'd4,
    ModeArgs    = 3'd5,
    ModeString  = 3'd6
  } lex_mode_e;

  localparam logic [2:0] KindText    = 3'd0;
  localparam logic [2:0] KindInclude = 3'd4;
  localparam logic [2:0] KindString  = 3'd5;

  localparam logic [2:0] ErrNone       = 3'd0;
  localparam logic [2:0] ErrIdent      = 3'd1;
  localparam logic [2:0] ErrFile       = 3'd2;
  localparam logic [2:0] ErrEmptyInc   = 3'd3;
  localparam logic [2:0] ErrArgChar    = 3'd4;
  localparam logic [2:0] ErrUntermTag  = 3'd5;
  localparam logic [2:0] ErrUntermStr  = 3'd6;

  localparam logic [7:0] ChBraceOpen  = 8'h7B;
  localparam logic [7:0] ChBraceClose = 8'h7D;
  localparam logic [7:0] ChHash       = 8'h23;
  localparam logic [7:0] ChSlash      = 8'h2F;
  localparam logic [7:0] ChDollar     = 8'h24;
  localparam logic [7:0] ChEquals     = 8'h3D;
  localparam logic [7:0] ChBackslash  = 8'h5C;
  localparam logic [7:0] ChSQuote     = 8'h27;
  localparam logic [7:0] ChDQuote     = 8'h22;
  localparam logic [7:0] ChCr         = 8'h0D;
  localparam logic [7:0] ChLf         = 8'h0A;
  localparam logic [7:0] ChTab        = 8'h09;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChUnder      = 8'h5F;
  localparam logic [7:0] ChDash       = 8'h2D;
  localparam logic [7:0] ChDot        = 8'h2E;

  // Output queue depth; input is taken while two slots are free.
  localparam int unsigned Depth = 4;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       bval;
    logic       tend;
    logic [2:0] err;
    logic       last;
  } result_t;

  function automatic logic ident_char(input logic [7:0] c);
    return (c == ChUnder) || (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic file_char(input logic [7:0] c);
    return ident_char(c) || (c == ChDash) || (c == ChDot);
  endfunction

  function automatic logic blank_char(input logic [7:0] c);
    return (c == ChCr) || (c == ChLf) || (c == ChTab) || (c == ChSpace);
  endfunction

  function automatic logic [2:0] kind_of(input lex_mode_e m);
    logic [2:0] k;
    unique case (m)
      ModeOpen, ModeClose, ModeSymbol, ModeInclude: k = 3'(m);
      ModeArgs:   k = KindInclude;
      ModeString: k = KindString;
      default:    k = KindText;
    endcase
    return k;
  endfunction

  function automatic result_t mk(input logic [2:0] kind, input logic [7:0] data,
                                 input logic bval, input logic tend,
                                 input logic [2:0] err);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.bval = bval;
    r.tend = tend;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/template_tag_lexer_core.sv =====
// Template tag lexer.
// Input channel (in_valid_i/in_ready_o) carries one template byte per transfer,
// or an end marker (is_end_i) that flushes pending text, checks for an open tag
// or string and returns the lexer to text mode. Output channel
// (out_valid_o/out_ready_i) carries token results: kind, byte, flags, error code,
// with last_o marking the final result caused by an input transfer.
// Each input byte is lexed in the cycle it is transferred; its zero, one or two
// results are registered into a four-entry output queue. Results leave at one
// per cycle while out_ready_i is high; the input side sustains one byte per
// cycle while out_ready_i is high and no more than one result per byte is made.
// in_ready_o is high while the queue has two free slots, so a stalled receiver
// blocks the input once fewer than two slots are free. Results are never dropped.
// Reset empties the queue and puts the lexer into text mode with no held brace,
// no pending newline skip and no latched error. After an error only the end
// marker is acted on.
module template_tag_lexer_core
  import tlex_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       is_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       token_end_o,
  output logic [2:0] error_code_o,
  output logic       last_o
);

  `include "template_tag_lexer_core_assert.svh"

  lex_mode_e mode_q, mode_d;
  logic brace_q, brace_d;
  logic skip_nl_q, skip_nl_d;
  logic dquote_q, dquote_d;
  logic esc_q, esc_d;
  logic nonempty_q, nonempty_d;
  logic err_q, err_d;

  result_t q_q [Depth];
  result_t q_d [Depth];
  logic [CntW-1:0] cnt_q, cnt_d;

  logic in_acc, pop;
  logic [1:0] n;
  result_t r0, r1, r0_f, r1_f;
  logic [7:0] c;
  logic [7:0] delim;

  assign in_ready_o = (cnt_q <= CntW'(Depth - 2));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign pop        = out_valid_o && out_ready_i;
  assign c          = char_byte_i;
  assign delim      = dquote_q ? ChDQuote : ChSQuote;

  // Lexer step for the byte at the input ports.
  always_comb begin
    n          = 2'd0;
    r0         = '0;
    r1         = '0;
    mode_d     = mode_q;
    brace_d    = brace_q;
    skip_nl_d  = skip_nl_q;
    dquote_d   = dquote_q;
    esc_d      = esc_q;
    nonempty_d = nonempty_q;
    err_d      = err_q;
    if (is_end_i) begin
      if (!err_q) begin
        if (mode_q == ModeString) begin
          n  = 2'd1;
          r0 = mk(kind_of(mode_q), 8'h00, 1'b0, 1'b1, ErrUntermStr);
        end else if (mode_q != ModeText) begin
          n  = 2'd1;
          r0 = mk(kind_of(mode_q), 8'h00, 1'b0, 1'b1, ErrUntermTag);
        end else if (brace_q) begin
          n  = 2'd2;
          r0 = mk(KindText, ChBraceOpen, 1'b1, 1'b0, ErrNone);
          r1 = mk(KindText, 8'h00, 1'b0, 1'b1, ErrNone);
        end else if (nonempty_q) begin
          n  = 2'd1;
          r0 = mk(KindText, 8'h00, 1'b0, 1'b1, ErrNone);
        end
      end
      mode_d     = ModeText;
      brace_d    = 1'b0;
      skip_nl_d  = 1'b0;
      dquote_d   = 1'b0;
      esc_d      = 1'b0;
      nonempty_d = 1'b0;
      err_d      = 1'b0;
    end else if (!err_q) begin
      unique case (mode_q)
        ModeOpen, ModeClose, ModeSymbol: begin
          if (ident_char(c)) begin
            n  = 2'd1;
            r0 = mk(kind_of(mode_q), c, 1'b1, 1'b0, ErrNone);
          end else if (c == ChBraceClose) begin
            n          = 2'd1;
            r0         = mk(kind_of(mode_q), 8'h00, 1'b0, 1'b1, ErrNone);
            skip_nl_d  = (mode_q != ModeSymbol);
            mode_d     = ModeText;
            nonempty_d = 1'b0;
          end else begin
            n     = 2'd1;
            r0    = mk(kind_of(mode_q), 8'h00, 1'b0, 1'b1, ErrIdent);
            err_d = 1'b1;
          end
        end
        ModeInclude: begin
          if (file_char(c)) begin
            n          = 2'd1;
            r0         = mk(KindInclude, c, 1'b1, 1'b0, ErrNone);
            nonempty_d = 1'b1;
          end else if (c == ChBraceClose || blank_char(c)) begin
            n = 2'd1;
            if (!nonempty_q) begin
              r0    = mk(KindInclude, 8'h00, 1'b0, 1'b1, ErrEmptyInc);
              err_d = 1'b1;
            end else begin
              r0         = mk(KindInclude, 8'h00, 1'b0, 1'b1, ErrNone);
              nonempty_d = 1'b0;
              if (c == ChBraceClose) begin
                mode_d    = ModeText;
                skip_nl_d = 1'b1;
              end else begin
                mode_d = ModeArgs;
              end
            end
          end else begin
            n     = 2'd1;
            r0    = mk(KindInclude, 8'h00, 1'b0, 1'b1, ErrFile);
            err_d = 1'b1;
          end
        end
        ModeArgs: begin
          if (c == ChSQuote || c == ChDQuote) begin
            mode_d   = ModeString;
            dquote_d = (c == ChDQuote);
            esc_d    = 1'b0;
          end else if (c == ChBraceClose) begin
            mode_d    = ModeText;
            skip_nl_d = 1'b1;
          end else if (!blank_char(c)) begin
            n     = 2'd1;
            r0    = mk(KindInclude, 8'h00, 1'b0, 1'b1, ErrArgChar);
            err_d = 1'b1;
          end
        end
        ModeString: begin
          if (esc_q) begin
            esc_d = 1'b0;
            if (c == delim || c == ChBackslash || c == ChCr || c == ChLf ||
                c == ChTab) begin
              n  = 2'd1;
              r0 = mk(KindString, c, 1'b1, 1'b0, ErrNone);
            end else begin
              // unknown escape keeps its backslash
              n  = 2'd2;
              r0 = mk(KindString, ChBackslash, 1'b1, 1'b0, ErrNone);
              r1 = mk(KindString, c, 1'b1, 1'b0, ErrNone);
            end
          end else if (c == delim) begin
            n      = 2'd1;
            r0     = mk(KindString, 8'h00, 1'b0, 1'b1, ErrNone);
            mode_d = ModeArgs;
          end else if (c == ChBackslash) begin
            esc_d = 1'b1;
          end else begin
            n  = 2'd1;
            r0 = mk(KindString, c, 1'b1, 1'b0, ErrNone);
          end
        end
        default: begin
          mode_d = ModeText;
          if (brace_q) begin
            if (c == ChHash || c == ChSlash || c == ChDollar || c == ChEquals) begin
              brace_d = 1'b0;
              if (nonempty_q) begin
                n  = 2'd1;
                r0 = mk(KindText, 8'h00, 1'b0, 1'b1, ErrNone);
              end
              nonempty_d = 1'b0;
              if (c == ChHash)        mode_d = ModeOpen;
              else if (c == ChSlash)  mode_d = ModeClose;
              else if (c == ChDollar) mode_d = ModeSymbol;
              else                    mode_d = ModeInclude;
            end else begin
              r0         = mk(KindText, ChBraceOpen, 1'b1, 1'b0, ErrNone);
              nonempty_d = 1'b1;
              if (c != ChBraceOpen) begin
                n       = 2'd2;
                brace_d = 1'b0;
                r1      = mk(KindText, c, 1'b1, 1'b0, ErrNone);
              end else begin
                n = 2'd1;
              end
            end
          end else if (skip_nl_q && (c == ChCr || c == ChLf)) begin
            skip_nl_d = 1'b0;
          end else begin
            skip_nl_d = 1'b0;
            if (c == ChBraceOpen) begin
              brace_d = 1'b1;
            end else begin
              n          = 2'd1;
              r0         = mk(KindText, c, 1'b1, 1'b0, ErrNone);
              nonempty_d = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Mark the final result of the step.
  always_comb begin
    r0_f      = r0;
    r1_f      = r1;
    r0_f.last = (n == 2'd1);
    r1_f.last = (n == 2'd2);
  end

  // Shifting output queue: slot 0 is the head.
  always_comb begin
    logic [CntW-1:0] base;
    logic [1:0]      push_n;
    push_n = in_acc ? n : 2'd0;
    base   = cnt_q - CntW'(pop);
    for (int i = 0; i < Depth; i++) begin
      if (pop && (i < Depth - 1)) begin
        q_d[i] = q_q[(i < Depth - 1) ? i + 1 : i];
      end else begin
        q_d[i] = q_q[i];
      end
      if ((push_n != 2'd0) && (CntW'(i) == base)) begin
        q_d[i] = r0_f;
      end
      if ((push_n == 2'd2) && (CntW'(i) == base + CntW'(1))) begin
        q_d[i] = r1_f;
      end
    end
    cnt_d = base + CntW'(push_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeText;
      brace_q    <= 1'b0;
      skip_nl_q  <= 1'b0;
      dquote_q   <= 1'b0;
      esc_q      <= 1'b0;
      nonempty_q <= 1'b0;
      err_q      <= 1'b0;
      cnt_q      <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        mode_q     <= mode_d;
        brace_q    <= brace_d;
        skip_nl_q  <= skip_nl_d;
        dquote_q   <= dquote_d;
        esc_q      <= esc_d;
        nonempty_q <= nonempty_d;
        err_q      <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign token_kind_o = q_q[0].kind;
  assign out_byte_o   = q_q[0].data;
  assign byte_valid_o = q_q[0].bval;
  assign token_end_o  = q_q[0].tend;
  assign error_code_o = q_q[0].err;
  assign last_o       = q_q[0].last;

  `TLEX_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CntW'(Depth))
  `TLEX_ASSERT_IMPL(a_room_for_two, in_ready_o, cnt_q + CntW'(2) <= CntW'(Depth))
  `TLEX_ASSERT_IMPL(a_latched_silent, in_acc && err_q && !is_end_i, n == 2'd0)
  `TLEX_ASSERT_NEXT(a_end_clears, in_acc && is_end_i,
                    mode_q == ModeText && !brace_q && !err_q && !nonempty_q)
  `TLEX_ASSERT_NEXT(a_error_latches, in_acc && !is_end_i && n != 2'd0 && r0.err != ErrNone,
                    err_q)

endmodule
